/* rtl/core/decimal_amount_to_fixed_point_defines.svh */
// ----------------------------------------------------------------------------
// decimal amount to fixed point: assertion macros
// shared concurrent assertion forms, clocked on aclk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef DECIMAL_AMOUNT_TO_FIXED_POINT_DEFINES_SVH
`define DECIMAL_AMOUNT_TO_FIXED_POINT_DEFINES_SVH

// same-cycle implication
`define DAFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dafp assertion failed");

// next-cycle implication
`define DAFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dafp assertion failed");

`endif

/* rtl/core/dafp_pkg.sv */
// ----------------------------------------------------------------------------
// dafp_pkg
// constants, types and helpers shared by the decimal amount converter
// ----------------------------------------------------------------------------
package dafp_pkg;

    localparam int AMOUNT_W = 63;
    localparam int CHAR_W   = 8;
    localparam int FRACTION_DIGITS_DEFAULT = 8;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // status that travels with a finished string
    typedef struct packed {
        logic rejected;
        logic scaled_ovf;
        logic divisible;
    } dafp_flags_t;

    // ten to the n, n up to 18
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < 18; i++) begin
            if (i < n) begin
                r = r * 64'd10;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/dafp_scan.sv */
// ----------------------------------------------------------------------------
// dafp_scan
// per-character parse state: integer, scaled integer and fraction accumulators
// ----------------------------------------------------------------------------
module dafp_scan #(
    parameter int FRACTION_DIGITS = dafp_pkg::FRACTION_DIGITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               take,
    input  logic [dafp_pkg::CHAR_W-1:0]        character,
    input  logic                               last_char,
    input  logic                               divisible,
    output logic [dafp_pkg::AMOUNT_W-1:0]      int_next,
    output logic [dafp_pkg::AMOUNT_W-1:0]      scaled_next,
    output logic [$clog2(dafp_pkg::pow10(FRACTION_DIGITS))-1:0] frac_next,
    output dafp_pkg::dafp_flags_t              flags_next
);

    localparam int FRAC_W = $clog2(dafp_pkg::pow10(FRACTION_DIGITS));
    localparam int CNT_W  = $clog2(FRACTION_DIGITS + 1);
    localparam int IDX_W  = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
    localparam int SUM_W  = dafp_pkg::AMOUNT_W + 4;
    localparam logic [63:0] UNIT = dafp_pkg::pow10(FRACTION_DIGITS);

    logic [dafp_pkg::AMOUNT_W-1:0] int_reg;
    logic [dafp_pkg::AMOUNT_W-1:0] scaled_reg;
    logic [FRAC_W-1:0]             frac_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          seen_point_reg;
    logic                          rejected_reg;
    logic                          ovf_reg;
    logic                          first_reg;

    logic [CNT_W-1:0] count_next;
    logic             seen_point_next;
    logic             first_next;

    logic [FRAC_W-1:0] place_tbl [FRACTION_DIGITS];
    logic [3:0]        digit;
    logic              is_digit;
    logic              in_frac;
    logic [63:0]       digit_unit;
    logic [FRAC_W-1:0] frac_add;
    logic [SUM_W-1:0]  int_sum;
    logic [SUM_W-1:0]  scaled_sum;

    // weight of each fraction slot
    for (genvar k = 0; k < FRACTION_DIGITS; k++) begin : g_place
        assign place_tbl[k] = FRAC_W'(dafp_pkg::pow10(FRACTION_DIGITS - 1 - k));
    end

    assign digit      = character[3:0];
    assign is_digit   = character inside {[dafp_pkg::CHAR_ZERO:dafp_pkg::CHAR_NINE]};
    assign in_frac    = divisible && seen_point_reg;
    assign digit_unit = UNIT * {60'd0, digit};
    assign frac_add   = place_tbl[count_reg[IDX_W-1:0]] * FRAC_W'(digit);
    assign int_sum    = ({4'd0, int_reg} << 3) + ({4'd0, int_reg} << 1) + SUM_W'(digit);
    assign scaled_sum = ({4'd0, scaled_reg} << 3) + ({4'd0, scaled_reg} << 1)
                      + SUM_W'(digit_unit);

    always_comb begin
        int_next             = int_reg;
        scaled_next          = scaled_reg;
        frac_next            = frac_reg;
        count_next           = count_reg;
        seen_point_next      = seen_point_reg;
        first_next           = first_reg;
        flags_next.rejected  = rejected_reg;
        flags_next.scaled_ovf = ovf_reg;
        flags_next.divisible = divisible;
        if (character == dafp_pkg::CHAR_MINUS) begin
            flags_next.rejected = 1'b1;
        end else if (character == dafp_pkg::CHAR_POINT) begin
            if (divisible && seen_point_reg) begin
                flags_next.rejected = 1'b1;
            end
            seen_point_next = 1'b1;
        end else if (seen_point_reg && !divisible) begin
            // integer-only mode ignores the tail
        end else if (in_frac && (count_reg >= CNT_W'(FRACTION_DIGITS))) begin
            // fraction digits beyond the kept slots are dropped
        end else begin
            if (in_frac) begin
                count_next = count_reg + CNT_W'(1);
            end
            first_next = 1'b0;
            if ((character == dafp_pkg::CHAR_PLUS) && first_reg) begin
                // leading plus sign
            end else if (!is_digit) begin
                flags_next.rejected = 1'b1;
            end else if (in_frac) begin
                frac_next = frac_reg + frac_add;
            end else if (!rejected_reg) begin
                if (|int_sum[SUM_W-1:dafp_pkg::AMOUNT_W]) begin
                    flags_next.rejected = 1'b1;
                end else begin
                    int_next = int_sum[dafp_pkg::AMOUNT_W-1:0];
                    if (|scaled_sum[SUM_W-1:dafp_pkg::AMOUNT_W]) begin
                        flags_next.scaled_ovf = 1'b1;
                    end else begin
                        scaled_next = scaled_sum[dafp_pkg::AMOUNT_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && last_char)) begin
            int_reg        <= '0;
            scaled_reg     <= '0;
            frac_reg       <= '0;
            count_reg      <= '0;
            seen_point_reg <= 1'b0;
            rejected_reg   <= 1'b0;
            ovf_reg        <= 1'b0;
            first_reg      <= 1'b1;
        end else if (take) begin
            int_reg        <= int_next;
            scaled_reg     <= scaled_next;
            frac_reg       <= frac_next;
            count_reg      <= count_next;
            seen_point_reg <= seen_point_next;
            rejected_reg   <= flags_next.rejected;
            ovf_reg        <= flags_next.scaled_ovf;
            first_reg      <= first_next;
        end
    end

endmodule

/* rtl/core/decimal_amount_to_fixed_point.sv */
// ----------------------------------------------------------------------------
// decimal_amount_to_fixed_point
// ascii amount string to non-negative 63-bit fixed-point amount
// ----------------------------------------------------------------------------
// One request carries one character of the amount string; the request with
// last_char set closes the string and produces exactly one result on the m_
// channel, all other requests produce none. In divisible mode the amount is
// scaled by ten to FRACTION_DIGITS (missing fraction digits count as zero,
// extra ones are dropped); in plain mode everything after the first point is
// ignored. A minus sign, a second point in divisible mode, a stray non-digit
// or a value above 2^63-1 gives an amount of zero. The block takes one
// character per clock cycle, but a closing character waits in the input
// register while the snapshot register is full. A string's result passes
// the input, snapshot and result registers in that order before m_valid
// rises. The per-character scan stage, which multiplies the running value
// by ten and adds the digit, sets the rate of one character per cycle.
// ----------------------------------------------------------------------------
`include "decimal_amount_to_fixed_point_defines.svh"

module decimal_amount_to_fixed_point #(
    parameter int FRACTION_DIGITS = dafp_pkg::FRACTION_DIGITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dafp_pkg::CHAR_W-1:0]   s_character,
    input  logic                          s_last_char,
    input  logic                          s_divisible,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dafp_pkg::AMOUNT_W-1:0] m_amount
);

    localparam int FRAC_W = $clog2(dafp_pkg::pow10(FRACTION_DIGITS));

    // input register
    logic                        in_valid_reg;
    logic [dafp_pkg::CHAR_W-1:0] in_char_reg;
    logic                        in_last_reg;
    logic                        in_div_reg;

    // snapshot of a finished string, waiting for the result stage
    logic                          snap_valid_reg;
    dafp_pkg::dafp_flags_t         snap_flags_reg;
    logic [dafp_pkg::AMOUNT_W-1:0] snap_int_reg;
    logic [dafp_pkg::AMOUNT_W-1:0] snap_scaled_reg;
    logic [FRAC_W-1:0]             snap_frac_reg;

    // result register
    logic                          m_valid_reg;
    logic [dafp_pkg::AMOUNT_W-1:0] m_amount_reg;
    logic [dafp_pkg::AMOUNT_W-1:0] m_amount_next;

    // scan outputs for the character in the input register
    logic [dafp_pkg::AMOUNT_W-1:0] int_next;
    logic [dafp_pkg::AMOUNT_W-1:0] scaled_next;
    logic [FRAC_W-1:0]             frac_next;
    dafp_pkg::dafp_flags_t         flags_next;

    // stage handshakes, each stage frees up when its successor takes
    logic snap_take;
    logic snap_ready;
    logic in_take;
    logic [dafp_pkg::AMOUNT_W:0] total;

    // a plain-mode string that was not rejected moves to the result stage
    logic plain_take;

    assign snap_take  = snap_valid_reg && (!m_valid_reg || m_ready);
    assign snap_ready = !snap_valid_reg || snap_take;
    // a character that does not close the string never waits
    assign in_take    = in_valid_reg && (!in_last_reg || snap_ready);
    assign s_ready    = !in_valid_reg || in_take;
    assign m_valid    = m_valid_reg;
    assign m_amount   = m_amount_reg;
    assign plain_take = snap_take && !snap_flags_reg.rejected && !snap_flags_reg.divisible;

    dafp_scan #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (in_take),
        .character  (in_char_reg),
        .last_char  (in_last_reg),
        .divisible  (in_div_reg),
        .int_next   (int_next),
        .scaled_next(scaled_next),
        .frac_next  (frac_next),
        .flags_next (flags_next)
    );

    // final amount: integer part times the unit plus the padded fraction
    assign total = {1'b0, snap_scaled_reg} + (dafp_pkg::AMOUNT_W + 1)'(snap_frac_reg);

    always_comb begin
        if (snap_flags_reg.rejected) begin
            m_amount_next = '0;
        end else if (!snap_flags_reg.divisible) begin
            m_amount_next = snap_int_reg;
        end else if (snap_flags_reg.scaled_ovf || total[dafp_pkg::AMOUNT_W]) begin
            m_amount_next = '0;
        end else begin
            m_amount_next = total[dafp_pkg::AMOUNT_W-1:0];
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (in_take) begin
                in_valid_reg <= 1'b0;
            end
            if (in_take && in_last_reg) begin
                snap_valid_reg <= 1'b1;
            end else if (snap_take) begin
                snap_valid_reg <= 1'b0;
            end
            if (snap_take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_character;
            in_last_reg <= s_last_char;
            in_div_reg  <= s_divisible;
        end
        if (in_take && in_last_reg) begin
            snap_flags_reg  <= flags_next;
            snap_int_reg    <= int_next;
            snap_scaled_reg <= scaled_next;
            snap_frac_reg   <= frac_next;
        end
        if (snap_take) begin
            m_amount_reg <= m_amount_next;
        end
    end

    // a rejected string always comes out as zero
    `DAFP_ASSERT_NEXT(a_reject_zero, snap_take && snap_flags_reg.rejected, m_amount_reg == '0)
    // plain mode passes the integer part straight through
    `DAFP_ASSERT_NEXT(a_plain_int, plain_take, m_amount_reg == $past(snap_int_reg))
    // only the closing character can be held in the input register
    `DAFP_ASSERT_NOW(a_mid_no_stall, in_valid_reg && !in_last_reg, in_take)

endmodule

/* dv/tb_decimal_amount_to_fixed_point.sv */
// ----------------------------------------------------------------------------
// tb_decimal_amount_to_fixed_point
// self-checking bench for the decimal amount to fixed-point converter
// ----------------------------------------------------------------------------
// Characters are sent one request at a time, and a local parser mirror
// predicts the amount of every string when its last character is taken.
// A checker compares each result against the oldest prediction. The test
// sequence is: directed corner strings, then random strings under three idle
// mixes, with a long receiver hold-off in between that fills the block up.
// ----------------------------------------------------------------------------
module tb_decimal_amount_to_fixed_point;

    localparam int          FRAC_DIGITS  = 8;
    localparam logic [63:0] AMOUNT_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          QUIET_LIMIT  = 4000;  // cycles with no handshake at all
    localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int          DRAIN_CYCLES = 12;    // margin after the last result arrives
    localparam int          MAX_REPORTS  = 10;

    typedef logic [dafp_pkg::CHAR_W-1:0] char_list_t[$];

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [dafp_pkg::CHAR_W-1:0]   s_character;
    logic                          s_last_char;
    logic                          s_divisible;
    logic                          m_valid;
    logic                          m_ready;
    logic [dafp_pkg::AMOUNT_W-1:0] m_amount;

    // mirror of the parser state
    logic [63:0] acc_integer;
    logic [63:0] acc_fraction;
    int unsigned frac_slots;
    bit          point_seen;
    bit          string_bad;
    bit          expect_sign;

    logic [dafp_pkg::AMOUNT_W-1:0] amount_queue[$];
    logic [dafp_pkg::AMOUNT_W-1:0] want_amount;
    int                            mismatches;
    int                            chars_sent;
    int                            send_idle_pct;
    int                            recv_idle_pct;
    int                            hold_len;

    decimal_amount_to_fixed_point #(
        .FRACTION_DIGITS(FRAC_DIGITS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_last_char (s_last_char),
        .s_divisible (s_divisible),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_amount    (m_amount)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // amount prediction
    // ------------------------------------------------------------------
    function automatic logic [63:0] ten_to(input int n);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < n; i++) begin
            r = r * 64'd10;
        end
        return r;
    endfunction

    function automatic void clear_parser();
        acc_integer  = '0;
        acc_fraction = '0;
        frac_slots   = 0;
        point_seen   = 1'b0;
        string_bad   = 1'b0;
        expect_sign  = 1'b1;
    endfunction

    function automatic void scan_char(input logic [dafp_pkg::CHAR_W-1:0] c,
                                      input bit div);
        bit          frac_part;
        logic [63:0] d;
        // a minus sign kills the string wherever it stands
        if (c == dafp_pkg::CHAR_MINUS) begin
            string_bad = 1'b1;
            return;
        end
        // a second point only matters in divisible mode
        if (c == dafp_pkg::CHAR_POINT) begin
            if (div && point_seen) begin
                string_bad = 1'b1;
            end
            point_seen = 1'b1;
            return;
        end
        // plain mode ignores everything after the point
        if (point_seen && !div) begin
            return;
        end
        frac_part = div && point_seen;
        // fraction characters past the kept slots are dropped unchecked
        if (frac_part && frac_slots >= FRAC_DIGITS) begin
            return;
        end
        if (frac_part) begin
            frac_slots++;
        end
        // leading plus, still allowed after a leading point
        if (c == dafp_pkg::CHAR_PLUS && expect_sign) begin
            expect_sign = 1'b0;
            return;
        end
        expect_sign = 1'b0;
        if (c < dafp_pkg::CHAR_ZERO || c > dafp_pkg::CHAR_NINE) begin
            string_bad = 1'b1;
            return;
        end
        d = 64'(c) - 64'(dafp_pkg::CHAR_ZERO);
        if (frac_part) begin
            acc_fraction = acc_fraction * 64'd10 + d;
        end else if (!string_bad) begin
            if (acc_integer > (AMOUNT_LIMIT - d) / 64'd10) begin
                string_bad = 1'b1;
            end else begin
                acc_integer = acc_integer * 64'd10 + d;
            end
        end
    endfunction

    // amount of the finished string under the last request's mode
    function automatic logic [dafp_pkg::AMOUNT_W-1:0] close_string(input bit div);
        logic [63:0] frac;
        logic [63:0] unit;
        logic [63:0] total;
        int          n;
        if (string_bad) begin
            total = '0;
        end else if (!div) begin
            total = acc_integer;
        end else begin
            n     = (frac_slots > FRAC_DIGITS) ? FRAC_DIGITS : frac_slots;
            frac  = acc_fraction * ten_to(FRAC_DIGITS - n);
            unit  = ten_to(FRAC_DIGITS);
            // scaled value above the 63-bit limit
            if (acc_integer > (AMOUNT_LIMIT - frac) / unit) begin
                total = '0;
            end else begin
                total = acc_integer * unit + frac;
            end
        end
        clear_parser();
        return total[dafp_pkg::AMOUNT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // entered and left at a falling edge; valid stays up on return so the
    // next call can present its request without a gap
    task automatic send_char(input logic [dafp_pkg::CHAR_W-1:0] c, input bit last,
                             input bit div);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_character <= c;
        s_last_char <= last;
        s_divisible <= div;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        chars_sent++;
        scan_char(c, div);
        if (last) begin
            amount_queue.push_back(close_string(div));
        end
        @(negedge aclk);
    endtask

    // mixed: the mode bit flips on some characters of the string
    task automatic send_chars(input char_list_t chars, input bit div, input bit mixed);
        bit d;
        for (int i = 0; i < chars.size(); i++) begin
            d = (mixed && $urandom_range(3) == 0) ? ~div : div;
            send_char(chars[i], i == chars.size() - 1, d);
        end
    endtask

    function automatic char_list_t text_chars(input string txt);
        char_list_t chars;
        for (int i = 0; i < txt.len(); i++) begin
            chars.push_back(txt[i]);
        end
        return chars;
    endfunction

    function automatic logic [dafp_pkg::CHAR_W-1:0] CHAR_ONE_OF(input string txt);
        return txt[0];
    endfunction

    function automatic logic [dafp_pkg::CHAR_W-1:0] rand_digit();
        return dafp_pkg::CHAR_ZERO + dafp_pkg::CHAR_W'($urandom_range(9));
    endfunction

    // any byte, with the characters the parser treats specially made common
    function automatic logic [dafp_pkg::CHAR_W-1:0] pick_special();
        case ($urandom_range(13))
            0:       return dafp_pkg::CHAR_PLUS;
            1:       return dafp_pkg::CHAR_MINUS;
            2:       return dafp_pkg::CHAR_POINT;
            3:       return dafp_pkg::CHAR_ZERO;
            4:       return dafp_pkg::CHAR_NINE;
            5:       return dafp_pkg::CHAR_ZERO - 8'd1;
            6:       return dafp_pkg::CHAR_NINE + 8'd1;
            default: return dafp_pkg::CHAR_W'($urandom_range(255));
        endcase
    endfunction

    task automatic random_string(input bit div);
        char_list_t chars;
        int         kind;
        int         ndig;
        int         pos;
        string      base;
        kind = $urandom_range(99);
        if (kind < 12) begin
            // right at the top of the amount range, last digit varied
            case ($urandom_range(3))
                0:       base = "9223372036854775807";
                1:       base = "92233720368.54775807";
                2:       base = "922337203685477580";
                default: base = "92233720368.5477580";
            endcase
            chars = text_chars(base);
            chars[chars.size() - 1] = rand_digit();
            if ($urandom_range(3) == 0) begin
                chars.push_back(rand_digit());
            end
        end else if (kind < 80) begin
            // amount, well-formed in divisible mode, optionally one stray character
            if ($urandom_range(4) == 0) begin
                chars.push_back(dafp_pkg::CHAR_PLUS);
            end
            ndig = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
            repeat (ndig) chars.push_back(rand_digit());
            if ($urandom_range(9) < 6) begin
                chars.push_back(dafp_pkg::CHAR_POINT);
                repeat ($urandom_range(0, 11)) begin
                    chars.push_back(div ? rand_digit() : pick_special());
                end
            end
            if (chars.size() == 0) begin
                chars.push_back(rand_digit());
            end
            if (kind >= 64) begin
                pos = $urandom_range(chars.size());
                chars.insert(pos, pick_special());
            end
        end else begin
            // short noise
            repeat ($urandom_range(1, 6)) chars.push_back(pick_special());
        end
        send_chars(chars, div, $urandom_range(19) == 0);
    endtask

    // lower valid, let every result arrive, settle, then switch idle mix
    task automatic drain(input int next_send_idle, input int next_recv_idle);
        s_valid <= 1'b0;
        while (amount_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        send_idle_pct = next_send_idle;
        recv_idle_pct = next_recv_idle;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_chars(text_chars("7"), 1'b0, 1'b0);      // single digit, plain
        send_chars(text_chars("-"), 1'b1, 1'b0);      // lone minus
        send_chars(text_chars("+.5"), 1'b1, 1'b0);    // plus then fraction
        send_chars(text_chars(".+"), 1'b1, 1'b0);     // plus after leading point
        send_chars(text_chars(".."), 1'b1, 1'b0);     // second point, divisible
        send_chars(text_chars("5.."), 1'b0, 1'b0);    // second point, plain
        send_chars(text_chars("3.-"), 1'b0, 1'b0);    // minus in ignored part
        send_chars(text_chars("+"), 1'b1, 1'b0);      // no digits at all
        send_chars(text_chars("++"), 1'b0, 1'b0);     // second plus
        send_char(8'h00, 1'b1, 1'b0);                 // lowest byte
        send_char(8'hFF, 1'b1, 1'b1);                 // highest byte
        send_char(CHAR_ONE_OF("1"), 1'b0, 1'b0);      // mode changes mid-string
        send_char(CHAR_ONE_OF("2"), 1'b1, 1'b1);
        send_chars(text_chars(".000000019"), 1'b1, 1'b0);  // ninth digit dropped
    endtask

    task automatic test_random(input int n_chars);
        int target;
        target = chars_sent + n_chars;
        while (chars_sent < target) begin
            random_string(1'($urandom_range(1)));
        end
    endtask

    // receiver holds off while short strings keep coming, so the block
    // fills and has to stall its input
    task automatic test_backpressure();
        @(posedge aclk);
        hold_len = HOLD_CYCLES;
        @(negedge aclk);
        repeat (40) begin
            send_chars(text_chars("12"), 1'($urandom_range(1)), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial begin : receiver
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_len > 0) begin
                m_ready <= 1'b0;
                hold_len--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (amount_queue.size() == 0) begin
                if (mismatches < MAX_REPORTS) begin
                    $display("amount %0d with no string pending", m_amount);
                end
                mismatches++;
            end else begin
                want_amount = amount_queue.pop_front();
                if (m_amount !== want_amount) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("amount: expected %0d, got %0d", want_amount, m_amount);
                    end
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any handshake on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : main
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_character   = '0;
        s_last_char   = 1'b0;
        s_divisible   = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 62;
        hold_len      = 0;
        mismatches    = 0;
        chars_sent    = 0;
        clear_parser();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        drain(28, 62);
        test_random(160);
        drain(62, 28);
        test_random(160);
        drain(0, 0);
        test_backpressure();
        drain(0, 0);
        test_random(160);
        drain(0, 0);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
